[rtl/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// Shared widths, constants and status types for the byte entropy block.
// ----------------------------------------------------------------------------
package bse_pkg;

   localparam int NUM_BINS  = 256;
   localparam int BIN_W     = 8;
   localparam int MAX_BYTES = 4096;
   localparam int CNT_W     = 13;
   localparam int FRAC_BITS = 16;
   localparam int LOG_FRAC  = 30;
   localparam int K_W       = 4;
   localparam int LOG_W     = K_W + LOG_FRAC;
   localparam int PROD_W    = CNT_W + LOG_W;
   localparam int SUM_W     = 48;
   localparam int ENT_W     = 20;
   localparam int Z_W       = 32;
   localparam int IT_W      = 5;
   localparam int DIV_IT_W  = 6;

   typedef struct packed {
      logic             done;
      logic [LOG_W-1:0] value;
   } lg_rsp_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/bse_if.sv]
// ----------------------------------------------------------------------------
// bse channel interfaces
// Valid/ready channels for byte items and entropy results.
// ----------------------------------------------------------------------------
interface bse_req_if;
   logic                     valid;
   logic                     ready;
   logic [bse_pkg::BIN_W-1:0] data_byte;
   logic                     byte_present;
   logic                     last;

   modport source (output valid, data_byte, byte_present, last, input ready);
   modport sink   (input valid, data_byte, byte_present, last, output ready);
endinterface

interface bse_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bse_pkg::ENT_W-1:0] entropy_bits;
   logic [bse_pkg::CNT_W-1:0] byte_count;
   logic                      overflow;

   modport source (output valid, entropy_bits, byte_count, overflow, input ready);
   modport sink   (input valid, entropy_bits, byte_count, overflow, output ready);
endinterface

[rtl/bse_log2.sv]
// ----------------------------------------------------------------------------
// bse_log2
// Iterative log2 with LOG_FRAC fraction bits by repeated squaring.
// ----------------------------------------------------------------------------
module bse_log2 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bse_pkg::CNT_W-1:0] x,
   output bse_pkg::lg_rsp_type       rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bse_pkg::IT_W-1:0]      it_ff, it_in;
   logic [bse_pkg::Z_W-1:0]       z_ff, z_in;
   logic [bse_pkg::K_W-1:0]       k_ff, k_in;
   logic [bse_pkg::LOG_FRAC-1:0]  frac_ff, frac_in;
   logic [2*bse_pkg::Z_W-1:0]     sq;
   logic [bse_pkg::K_W-1:0]       k_new;
   logic [bse_pkg::IT_W-1:0]      bit_idx;

   always_comb begin
      k_new = '0;
      for (int i = 0; i < bse_pkg::CNT_W; i++) begin
         if (x[i]) begin
            k_new = bse_pkg::K_W'(i);
         end
      end
   end

   assign sq      = 64'(z_ff) * 64'(z_ff);
   assign bit_idx = bse_pkg::IT_W'(bse_pkg::LOG_FRAC - 1) - it_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      it_in   = it_ff;
      z_in    = z_ff;
      k_in    = k_ff;
      frac_in = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         it_in   = '0;
         k_in    = k_new;
         frac_in = '0;
         z_in    = bse_pkg::Z_W'(x) << (bse_pkg::IT_W'(bse_pkg::Z_W - 1) - 5'(k_new));
      end else if (busy_ff) begin
         if (sq[2*bse_pkg::Z_W-1]) begin
            z_in             = sq[2*bse_pkg::Z_W-1:bse_pkg::Z_W];
            frac_in[bit_idx] = 1'b1;
         end else begin
            z_in = sq[2*bse_pkg::Z_W-2:bse_pkg::Z_W-1];
         end
         it_in = it_ff + 1'b1;
         if (it_ff == bse_pkg::IT_W'(bse_pkg::LOG_FRAC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      it_ff   <= it_in;
      z_ff    <= z_in;
      k_ff    <= k_in;
      frac_ff <= frac_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = {k_ff, frac_ff};

endmodule

[rtl/bse_div.sv]
// ----------------------------------------------------------------------------
// bse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bse_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bse_pkg::SUM_W-1:0] dividend,
   input  logic [bse_pkg::CNT_W-1:0] divisor,
   output bse_pkg::div_rsp_type      rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bse_pkg::DIV_IT_W-1:0]  it_ff, it_in;
   logic [bse_pkg::SUM_W-1:0]     dvd_ff, dvd_in;
   logic [bse_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [bse_pkg::CNT_W-1:0]     dsr_ff, dsr_in;
   logic [bse_pkg::CNT_W:0]       rem_sh;
   logic [bse_pkg::CNT_W:0]       rem_sub;

   assign rem_sh  = {rem_ff, dvd_ff[bse_pkg::SUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      it_in   = it_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         it_in   = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sub[bse_pkg::CNT_W-1:0];
            dvd_in = {dvd_ff[bse_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[bse_pkg::CNT_W-1:0];
            dvd_in = {dvd_ff[bse_pkg::SUM_W-2:0], 1'b0};
         end
         it_in = it_ff + 1'b1;
         if (it_ff == bse_pkg::DIV_IT_W'(bse_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      it_ff  <= it_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule

[rtl/byte_shannon_entropy_top.sv]
// ----------------------------------------------------------------------------
// byte_shannon_entropy_top
// Byte histogram and Shannon entropy of a block, bits per byte, Q.16.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one byte item per handshake; last closes the block.
//   rsp_ch returns one item per block: entropy_bits, byte_count, overflow.
//   A byte item is accepted in S_IDLE, which reads its bin, then written
//   back incremented in S_INC, so the next byte is taken only after the
//   write-back. An item without a byte, or a byte dropped on a full block,
//   skips S_INC. On last, a non-empty block walks all 256 bins, clearing
//   each; for an occupied bin it runs the log2 unit, then multiplies and
//   accumulates. Then come log2 of the count and a 48-step serial division.
//   req_ch.ready stays low during the walk and when a result is still
//   waiting on a stalled rsp_ch at the point a new one is ready.
//   After reset a clearing pass zeroes all 256 histogram bins with
//   req_ch.ready low.
// ----------------------------------------------------------------------------
module byte_shannon_entropy_top (
   input  logic         clock,
   input  logic         reset,
   bse_req_if.sink      req_ch,
   bse_rsp_if.source    rsp_ch
);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_INC   = 4'd2;
   localparam logic [3:0] S_WRD   = 4'd3;
   localparam logic [3:0] S_WCHK  = 4'd4;
   localparam logic [3:0] S_WLOG  = 4'd5;
   localparam logic [3:0] S_WACC  = 4'd6;
   localparam logic [3:0] S_LOGN  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_START = 4'd10;

   localparam int SHIFT = bse_pkg::LOG_FRAC - bse_pkg::FRAC_BITS;
   localparam int H_W   = bse_pkg::LOG_W + 2;
   localparam logic [H_W-1:0] RND = H_W'(1) << (SHIFT - 1);
   localparam logic [H_W-1:0] TOP = H_W'(8) << bse_pkg::FRAC_BITS;

   logic [bse_pkg::CNT_W-1:0] mem [bse_pkg::NUM_BINS];
   logic [bse_pkg::CNT_W-1:0] rd_data_ff;
   logic                      rd_en;
   logic [bse_pkg::BIN_W-1:0] rd_addr;
   logic                      wr_en;
   logic [bse_pkg::BIN_W-1:0] wr_addr;
   logic [bse_pkg::CNT_W-1:0] wr_data;

   logic [3:0]                 state_ff, state_in;
   logic [bse_pkg::BIN_W-1:0]  idx_ff, idx_in;
   logic [bse_pkg::BIN_W-1:0]  addr_ff, addr_in;
   logic                       last_ff, last_in;
   logic [bse_pkg::CNT_W-1:0]  total_ff, total_in;
   logic                       drop_ff, drop_in;
   logic [bse_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [bse_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [bse_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [bse_pkg::LOG_W-1:0]  logn_ff, logn_in;
   logic                       ovld_ff, ovld_in;
   logic [bse_pkg::ENT_W-1:0]  oent_ff, oent_in;
   logic [bse_pkg::CNT_W-1:0]  ocnt_ff, ocnt_in;
   logic                       oovf_ff, oovf_in;

   logic                       lg_start;
   logic [bse_pkg::CNT_W-1:0]  lg_x;
   bse_pkg::lg_rsp_type        lg_rsp;
   logic                       div_start;
   logic [bse_pkg::SUM_W-1:0]  div_dvd;
   bse_pkg::div_rsp_type       div_rsp;

   logic                       req_fire;
   logic [H_W-1:0]             h_val;
   logic [H_W-1:0]             q_val;
   logic [H_W-1:0]             out_val;

   bse_log2 u_log2 (
      .clock (clock),
      .reset (reset),
      .start (lg_start),
      .x     (lg_x),
      .rsp   (lg_rsp)
   );

   bse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (total_ff),
      .rsp      (div_rsp)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign div_dvd      = sum_ff + bse_pkg::SUM_W'(total_ff >> 1);

   assign q_val   = H_W'(div_rsp.quotient[bse_pkg::LOG_W:0]);
   assign h_val   = ({2'b00, logn_ff} > q_val) ? ({2'b00, logn_ff} - q_val) : '0;
   assign out_val = (h_val + RND) >> SHIFT;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      last_in   = last_ff;
      total_in  = total_ff;
      drop_in   = drop_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      logn_in   = logn_ff;
      ovld_in   = ovld_ff;
      oent_in   = oent_ff;
      ocnt_in   = ocnt_ff;
      oovf_in   = oovf_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = '0;
      lg_start  = 1'b0;
      lg_x      = cnt_ff;
      div_start = 1'b0;

      if (rsp_ch.valid && rsp_ch.ready) begin
         ovld_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               last_in = req_ch.last;
               addr_in = req_ch.data_byte;
               if (req_ch.byte_present &&
                   total_ff < bse_pkg::CNT_W'(bse_pkg::MAX_BYTES)) begin
                  rd_en    = 1'b1;
                  rd_addr  = req_ch.data_byte;
                  state_in = S_INC;
               end else begin
                  if (req_ch.byte_present) begin
                     drop_in = 1'b1;
                  end
                  if (req_ch.last) begin
                     state_in = S_START;
                  end
               end
            end
         end
         S_INC: begin
            wr_en    = 1'b1;
            wr_addr  = addr_ff;
            wr_data  = rd_data_ff + 1'b1;
            total_in = total_ff + 1'b1;
            state_in = last_ff ? S_START : S_IDLE;
         end
         S_START: begin
            idx_in   = '0;
            sum_in   = '0;
            logn_in  = '0;
            state_in = (total_ff == '0) ? S_FIN : S_WRD;
         end
         S_WRD: begin
            rd_en    = 1'b1;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            wr_en  = 1'b1;
            cnt_in = rd_data_ff;
            if (rd_data_ff != '0) begin
               lg_start = 1'b1;
               lg_x     = rd_data_ff;
               state_in = S_WLOG;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) ? S_LOGN : S_WRD;
            end
         end
         S_WLOG: begin
            if (lg_rsp.done) begin
               prod_in  = bse_pkg::PROD_W'(cnt_ff) * bse_pkg::PROD_W'(lg_rsp.value);
               state_in = S_WACC;
            end
         end
         S_WACC: begin
            sum_in = sum_ff + bse_pkg::SUM_W'(prod_ff);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) begin
               lg_start = 1'b1;
               lg_x     = total_ff;
               state_in = S_LOGN;
            end else begin
               state_in = S_WRD;
            end
         end
         S_LOGN: begin
            if (lg_rsp.done) begin
               logn_in   = lg_rsp.value;
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (idx_ff == '0 && cnt_ff == '0) begin
               lg_start = 1'b1;
               lg_x     = total_ff;
               cnt_in   = total_ff;
            end
         end
         S_DIV: begin
            if (div_rsp.done && !ovld_in) begin
               ovld_in  = 1'b1;
               oent_in  = (out_val > TOP) ? TOP[bse_pkg::ENT_W-1:0] :
                                            out_val[bse_pkg::ENT_W-1:0];
               ocnt_in  = total_ff;
               oovf_in  = drop_ff;
               total_in = '0;
               drop_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (!ovld_in) begin
               ovld_in  = 1'b1;
               oent_in  = '0;
               ocnt_in  = '0;
               oovf_in  = drop_ff;
               drop_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= '0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
         ovld_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
         drop_ff  <= drop_in;
         ovld_ff  <= ovld_in;
         cnt_ff   <= cnt_in;
      end
      addr_ff <= addr_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      logn_ff <= logn_in;
      oent_ff <= oent_in;
      ocnt_ff <= ocnt_in;
      oovf_ff <= oovf_in;
   end

   assign rsp_ch.valid        = ovld_ff;
   assign rsp_ch.entropy_bits = oent_ff;
   assign rsp_ch.byte_count   = ocnt_ff;
   assign rsp_ch.overflow     = oovf_ff;

endmodule

[rtl/bse_checker.sv]
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks on the byte entropy block, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bse_pkg::ENT_W-1:0] rsp_entropy,
   input logic [bse_pkg::CNT_W-1:0] rsp_count,
   input logic                      rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entropy) &&
                                  $stable(rsp_count) && $stable(rsp_overflow))
      else $error("result item changed while stalled");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("ready after a closing item");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_count == bse_pkg::CNT_W'(bse_pkg::MAX_BYTES))
      else $error("overflow without a full block");

   a_ent_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entropy <= (bse_pkg::ENT_W'(8) << bse_pkg::FRAC_BITS))
      else $error("entropy above 8 bits");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 |-> rsp_entropy == '0)
      else $error("empty block with nonzero entropy");

endmodule

bind byte_shannon_entropy_top bse_checker u_bse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_last     (req_ch.last),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_entropy  (rsp_ch.entropy_bits),
   .rsp_count    (rsp_ch.byte_count),
   .rsp_overflow (rsp_ch.overflow)
);
